### rtl/polygon_area_centroid_core_macros.svh
// ----------------------------------------------------------------------------
// Polygon area and centroid core: assertion macros
// Short forms for the concurrent checks at the end of the core. They expect
// clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef POLYGON_AREA_CENTROID_CORE_MACROS_SVH
`define POLYGON_AREA_CENTROID_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PAC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pac_pkg.sv
// ----------------------------------------------------------------------------
// Polygon area and centroid package
// Widths, status codes and the request and result types of the core.
// ----------------------------------------------------------------------------
package pac_pkg;

	// Coordinate and accumulator widths
	localparam int COORD_BITS       = 16;
	localparam int CROSS_BITS       = 44;
	localparam int WSUM_BITS        = 60;
	localparam int AREA_BITS        = 43;
	localparam int MAX_VERTICES_DEF = 1024;

	// Result status codes
	typedef enum logic [2:0] {
		STATUS_OK   = 3'd0,
		STATUS_FEW  = 3'd1,
		STATUS_ZERO = 3'd2,
		STATUS_SAT  = 3'd3,
		STATUS_MANY = 3'd4
	} status_t;

	// One vertex request
	typedef struct packed {
		logic signed [COORD_BITS-1:0] vertex_x;
		logic signed [COORD_BITS-1:0] vertex_y;
		logic                         last_vertex;
	} vertex_t;

	// One polygon result
	typedef struct packed {
		logic signed [COORD_BITS-1:0] centroid_x;
		logic signed [COORD_BITS-1:0] centroid_y;
		logic [AREA_BITS-1:0]         doubled_area;
		status_t                      status;
	} result_t;

endpackage

### rtl/polygon_area_centroid_core.sv
// ----------------------------------------------------------------------------
// Polygon area and centroid core
// Shoelace accumulation over one shared multiplier, then two restoring
// divisions for the centroid, all under one small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Vertices enter on the vertex channel (vertex_valid / vertex_stall), one
//   request each, with last_vertex set on the final vertex of a polygon.
//   One result per polygon leaves on the result channel (result_valid /
//   result_stall) after the flagged vertex.
//   Vertex handling: the first vertex of a polygon needs no multiplier pass;
//   every further vertex takes four passes through the shared
//   17 x 33 multiplier (two cross products, two weighted sums).
//   For a proper polygon the flagged vertex is followed by the closing edge
//   on the multiplier, then two 60-step divisions by three times the doubled
//   area, one quotient bit a cycle; polygons with under three or too many
//   vertices report without either, zero area without the divisions.
//   vertex_stall is high while a vertex or a polygon is being worked on.
//   A result waits in the output register while result_stall is high; the
//   core keeps taking vertices of the next polygon meanwhile and holds back
//   only when its next result is ready and the register is still full.
//   Reset clears the accumulators, the vertex count and the output valid.
// ----------------------------------------------------------------------------
`include "polygon_area_centroid_core_macros.svh"

module polygon_area_centroid_core
	import pac_pkg::*;
#(
	parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    vertex_valid,
	output logic    vertex_stall,
	input  vertex_t vertex,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// Derived widths
	localparam int CW        = $clog2(MAX_VERTICES + 2);
	localparam int PROD_BITS = 2 * COORD_BITS;
	localparam int Z_BITS    = PROD_BITS + 1;
	localparam int SUM_BITS  = COORD_BITS + 1;
	localparam int MUL_BITS  = SUM_BITS + Z_BITS;
	localparam int DW        = CROSS_BITS + 2;
	localparam int QW        = WSUM_BITS;
	localparam int DCW       = $clog2(QW);
	localparam int CMAX      = 2 ** (COORD_BITS - 1) - 1;
	localparam logic [CW-1:0]  MAX_CNT  = CW'(MAX_VERTICES);
	localparam logic [CW-1:0]  MIN_CNT  = CW'(3);
	localparam logic [DCW-1:0] LAST_BIT = DCW'(QW - 1);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_MUL1 = 11'b000_0000_0010,
		ST_MUL2 = 11'b000_0000_0100,
		ST_MUL3 = 11'b000_0000_1000,
		ST_MUL4 = 11'b000_0001_0000,
		ST_FIN  = 11'b000_0010_0000,
		ST_CHK  = 11'b000_0100_0000,
		ST_PREP = 11'b000_1000_0000,
		ST_DIV  = 11'b001_0000_0000,
		ST_QOUT = 11'b010_0000_0000,
		ST_EMIT = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Polygon state
	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CW-1:0]                count_q;
	logic                         last_q, closing_q;
	logic signed [CROSS_BITS-1:0] cross_q;
	logic signed [WSUM_BITS-1:0]  wx_q, wy_q;

	// Edge datapath
	logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [PROD_BITS-1:0]  p1_q;
	logic signed [Z_BITS-1:0]     z_q;
	logic signed [SUM_BITS-1:0]   sumx_q, sumy_q;
	logic signed [SUM_BITS-1:0]   mul_a;
	logic signed [Z_BITS-1:0]     mul_b;
	logic signed [MUL_BITS-1:0]   mul_p;

	// Division datapath
	logic signed [DW-1:0]         d_q;
	logic [DW-1:0]                dmag_q, rem_q;
	logic [QW-1:0]                num_q, num_abs;
	logic [DCW-1:0]               div_cnt_q;
	logic                         neg_q, sel_y_q, sat_q;
	logic signed [WSUM_BITS-1:0]  wsel;
	logic [DW:0]                  trial;
	logic [DW+1:0]                diff;
	logic                         ge;
	logic [CROSS_BITS-1:0]        c_abs;
	logic [COORD_BITS-1:0]        q_low;
	logic                         sat_now;
	logic signed [COORD_BITS-1:0] coord;

	// Result staging and output register
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic [AREA_BITS-1:0]         area_q;
	status_t                      status_q;
	logic                         result_valid_q;
	result_t                      result_q;

	logic accept, emit_go;

	assign vertex_stall = (state_q != ST_IDLE);
	assign accept       = vertex_valid && !vertex_stall;
	assign emit_go      = (state_q == ST_EMIT) && (!result_valid_q || !result_stall);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Select the operands of the shared multiplier
	always_comb begin
		case (state_q)
			ST_MUL1: begin
				mul_a = SUM_BITS'(ax_q);
				mul_b = Z_BITS'(by_q);
			end
			ST_MUL2: begin
				mul_a = SUM_BITS'(bx_q);
				mul_b = Z_BITS'(ay_q);
			end
			ST_MUL3: begin
				mul_a = sumx_q;
				mul_b = z_q;
			end
			ST_MUL4: begin
				mul_a = sumy_q;
				mul_b = z_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = MUL_BITS'(mul_a) * MUL_BITS'(mul_b);

	// Magnitudes and one restoring division step
	assign c_abs   = cross_q[CROSS_BITS-1] ? -cross_q : cross_q;
	assign wsel    = sel_y_q ? wy_q : wx_q;
	assign num_abs = wsel[WSUM_BITS-1] ? -wsel : wsel;
	assign trial   = {rem_q, num_q[QW-1]};
	assign diff    = {1'b0, trial} - {2'b00, dmag_q};
	assign ge      = !diff[DW+1];

	// Clamp the quotient to the coordinate range
	assign q_low   = num_q[COORD_BITS-1:0];
	assign sat_now = neg_q ? (num_q > QW'(CMAX + 1)) : (num_q > QW'(CMAX));
	always_comb begin
		if (sat_now) begin
			coord = neg_q ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
		end else begin
			coord = neg_q ? -q_low : q_low;
		end
	end

	// Sequencer, accumulators and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			cross_q        <= '0;
			wx_q           <= '0;
			wy_q           <= '0;
			last_q         <= 1'b0;
			closing_q      <= 1'b0;
			sel_y_q        <= 1'b0;
			sat_q          <= 1'b0;
			div_cnt_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// Raise the valid on a new result, drop it once the result is taken
			if (emit_go) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q    <= vertex.last_vertex;
						closing_q <= 1'b0;
						if (count_q <= MAX_CNT) begin
							count_q <= count_q + CW'(1);
						end
						if (count_q != '0 && count_q < MAX_CNT) begin
							state_q <= ST_MUL1;
						end else if (vertex.last_vertex) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: begin
					cross_q <= cross_q + CROSS_BITS'(z_q);
					wx_q    <= wx_q + WSUM_BITS'(mul_p);
					state_q <= ST_MUL4;
				end
				ST_MUL4: begin
					wy_q <= wy_q + WSUM_BITS'(mul_p);
					if (closing_q) begin
						state_q <= ST_CHK;
					end else if (last_q) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					if (count_q > MAX_CNT || count_q < MIN_CNT) begin
						state_q <= ST_EMIT;
					end else begin
						closing_q <= 1'b1;
						state_q   <= ST_MUL1;
					end
				end
				ST_CHK: begin
					sel_y_q <= 1'b0;
					sat_q   <= 1'b0;
					state_q <= (cross_q == '0) ? ST_EMIT : ST_PREP;
				end
				ST_PREP: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == LAST_BIT) begin
						state_q <= ST_QOUT;
					end
				end
				ST_QOUT: begin
					sat_q <= sat_q | sat_now;
					if (sel_y_q) begin
						state_q <= ST_EMIT;
					end else begin
						sel_y_q <= 1'b1;
						state_q <= ST_PREP;
					end
				end
				ST_EMIT: begin
					// Start a fresh polygon once the output register is loaded
					if (emit_go) begin
						count_q <= '0;
						cross_q <= '0;
						wx_q    <= '0;
						wy_q    <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Operand, division and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (count_q == '0) begin
						first_x_q <= vertex.vertex_x;
						first_y_q <= vertex.vertex_y;
					end
					if (count_q < MAX_CNT) begin
						prev_x_q <= vertex.vertex_x;
						prev_y_q <= vertex.vertex_y;
					end
					ax_q <= prev_x_q;
					ay_q <= prev_y_q;
					bx_q <= vertex.vertex_x;
					by_q <= vertex.vertex_y;
				end
			end
			ST_MUL1: begin
				p1_q <= mul_p[PROD_BITS-1:0];
			end
			ST_MUL2: begin
				z_q    <= Z_BITS'(p1_q) - Z_BITS'($signed(mul_p[PROD_BITS-1:0]));
				sumx_q <= SUM_BITS'(ax_q) + SUM_BITS'(bx_q);
				sumy_q <= SUM_BITS'(ay_q) + SUM_BITS'(by_q);
			end
			ST_FIN: begin
				// Close the polygon back to its first vertex
				ax_q     <= prev_x_q;
				ay_q     <= prev_y_q;
				bx_q     <= first_x_q;
				by_q     <= first_y_q;
				cx_q     <= '0;
				cy_q     <= '0;
				area_q   <= '0;
				status_q <= (count_q > MAX_CNT) ? STATUS_MANY : STATUS_FEW;
			end
			ST_CHK: begin
				d_q      <= DW'(cross_q) + (DW'(cross_q) <<< 1);
				area_q   <= c_abs[AREA_BITS-1:0];
				cx_q     <= '0;
				cy_q     <= '0;
				status_q <= STATUS_ZERO;
			end
			ST_PREP: begin
				dmag_q <= d_q[DW-1] ? -d_q : d_q;
				num_q  <= num_abs;
				neg_q  <= wsel[WSUM_BITS-1] ^ d_q[DW-1];
				rem_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
				num_q <= {num_q[QW-2:0], ge};
			end
			ST_QOUT: begin
				if (sel_y_q) begin
					cy_q     <= coord;
					status_q <= (sat_q || sat_now) ? STATUS_SAT : STATUS_OK;
				end else begin
					cx_q <= coord;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					result_q.centroid_x   <= cx_q;
					result_q.centroid_y   <= cy_q;
					result_q.doubled_area <= area_q;
					result_q.status       <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Checks
	`PAC_ASSERT_NEXT(a_clear_after_emit, emit_go, (count_q == '0) && (cross_q == '0) && (state_q == ST_IDLE), "polygon state not cleared after result")
	`PAC_ASSERT_SAME(a_div_cnt_range, state_q == ST_DIV, div_cnt_q <= LAST_BIT, "division step count out of range")
	`PAC_ASSERT_SAME(a_area_nonzero, result_valid_q && (result_q.status == STATUS_OK || result_q.status == STATUS_SAT), result_q.doubled_area != '0, "centroid given for zero area")
	`PAC_ASSERT_SAME(a_closing_valid, closing_q && (state_q == ST_MUL1), (count_q >= MIN_CNT) && (count_q <= MAX_CNT), "closing edge on degenerate polygon")

endmodule

### test/tb_polygon_area_centroid_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon area and centroid core: testbench
// Sends polygons one vertex request at a time. These are a short table of
// corner cases, one polygon at the vertex limit and one just past it, and
// then random shapes. Every result is checked against an in-bench shoelace
// predictor or a typed expected result. The vertex channel idles and the result channel stalls at random.
// ----------------------------------------------------------------------------
module tb_polygon_area_centroid_core;
	import pac_pkg::*;

	localparam logic signed [COORD_BITS-1:0] COORD_MAX = 16'sh7fff;
	localparam logic signed [COORD_BITS-1:0] COORD_MIN = 16'sh8000;
	localparam int RANDOM_VERTICES  = 600;
	localparam int LONG_HOLD_CYCLES = 800;
	localparam int SETTLE_CYCLES    = 300;

	localparam result_t FEW_RESULT  = '{16'sd0, 16'sd0, 43'd0, STATUS_FEW};
	localparam result_t ZERO_RESULT = '{16'sd0, 16'sd0, 43'd0, STATUS_ZERO};
	localparam result_t MANY_RESULT = '{16'sd0, 16'sd0, 43'd0, STATUS_MANY};
	localparam result_t SAT_RESULT  = '{COORD_MIN, -16'sd333, 43'd60000, STATUS_SAT};

	// One row of the corner-case table; want counts only where typed is set
	typedef struct packed {
		vertex_t req;
		bit      typed;
		result_t want;
	} directed_row_t;

	directed_row_t directed_rows [23] = '{
		// lone vertex straight after reset
		'{'{COORD_MAX, COORD_MIN, 1'b1}, 1'b1, FEW_RESULT},
		// two vertices at opposite corners
		'{'{COORD_MIN, COORD_MIN, 1'b0}, 1'b0, '0},
		'{'{COORD_MAX, COORD_MAX, 1'b1}, 1'b1, FEW_RESULT},
		// collinear vertices give no area
		'{'{16'sd1, 16'sd1, 1'b0}, 1'b0, '0},
		'{'{-16'sd2, -16'sd2, 1'b0}, 1'b0, '0},
		'{'{COORD_MAX, COORD_MAX, 1'b1}, 1'b1, ZERO_RESULT},
		// full-range triangle, anticlockwise
		'{'{COORD_MIN, COORD_MIN, 1'b0}, 1'b0, '0},
		'{'{COORD_MAX, COORD_MIN, 1'b0}, 1'b0, '0},
		'{'{COORD_MAX, COORD_MAX, 1'b1}, 1'b0, '0},
		// full-range triangle, clockwise
		'{'{COORD_MIN, COORD_MIN, 1'b0}, 1'b0, '0},
		'{'{COORD_MAX, COORD_MAX, 1'b0}, 1'b0, '0},
		'{'{COORD_MAX, COORD_MIN, 1'b1}, 1'b0, '0},
		// small square
		'{'{16'sd0, 16'sd0, 1'b0}, 1'b0, '0},
		'{'{16'sd4, 16'sd0, 1'b0}, 1'b0, '0},
		'{'{16'sd4, 16'sd4, 1'b0}, 1'b0, '0},
		'{'{16'sd0, 16'sd4, 1'b1}, 1'b0, '0},
		// negative centroid, truncated toward zero
		'{'{-16'sd1, -16'sd1, 1'b0}, 1'b0, '0},
		'{'{-16'sd4, -16'sd1, 1'b0}, 1'b0, '0},
		'{'{-16'sd1, -16'sd5, 1'b1}, 1'b0, '0},
		// lopsided bowtie: tiny net area, centroid far out of range
		'{'{-16'sd30000, -16'sd1000, 1'b0}, 1'b0, '0},
		'{'{16'sd30000, 16'sd1000, 1'b0}, 1'b0, '0},
		'{'{16'sd30000, -16'sd999, 1'b0}, 1'b0, '0},
		'{'{-16'sd30000, 16'sd1000, 1'b1}, 1'b1, SAT_RESULT}
	};

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    vertex_valid = 1'b0;
	logic    vertex_stall;
	vertex_t vertex       = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// Shoelace state of the polygon being received
	longint          open_first_x, open_first_y, open_prev_x, open_prev_y;
	int unsigned     open_count;
	logic [CROSS_BITS-1:0] cross_acc;
	logic [WSUM_BITS-1:0]  moment_x_acc, moment_y_acc;

	result_t results_due [$];
	int      mismatches    = 0;
	int      vertices_sent = 0;
	int      burst_left    = 0;
	bit      hold_off_due  = 1'b0;

	polygon_area_centroid_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex       (vertex),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #4 clk = ~clk;

	// Add one edge a -> b to the cross and moment sums, wrapping at their widths
	function automatic void accumulate_edge(input longint ax, input longint ay,
			input longint bx, input longint by);
		longint z;
		longint mx;
		longint my;
		z = ax * by - bx * ay;
		mx = (ax + bx) * z;
		my = (ay + by) * z;
		cross_acc    = cross_acc + z[CROSS_BITS-1:0];
		moment_x_acc = moment_x_acc + mx[WSUM_BITS-1:0];
		moment_y_acc = moment_y_acc + my[WSUM_BITS-1:0];
	endfunction

	function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint q,
			inout bit sat);
		if (q > longint'(COORD_MAX)) begin
			sat = 1'b1;
			return COORD_MAX;
		end
		if (q < longint'(COORD_MIN)) begin
			sat = 1'b1;
			return COORD_MIN;
		end
		return q[COORD_BITS-1:0];
	endfunction

	// Take one vertex; return 1 with the polygon result when it closes one
	function automatic bit shoelace_step(input vertex_t v, output result_t res);
		longint x;
		longint y;
		longint c;
		longint sx;
		longint sy;
		longint mag;
		bit     sat;
		x = v.vertex_x;
		y = v.vertex_y;
		res = '0;
		if (open_count == 0) begin
			open_first_x = x;
			open_first_y = y;
		end else if (open_count < MAX_VERTICES_DEF) begin
			accumulate_edge(open_prev_x, open_prev_y, x, y);
		end
		if (open_count < MAX_VERTICES_DEF) begin
			open_prev_x = x;
			open_prev_y = y;
		end
		if (open_count <= MAX_VERTICES_DEF)
			open_count++;
		if (!v.last_vertex)
			return 1'b0;

		if (open_count > MAX_VERTICES_DEF) begin
			res.status = STATUS_MANY;
		end else if (open_count < 3) begin
			res.status = STATUS_FEW;
		end else begin
			accumulate_edge(open_prev_x, open_prev_y, open_first_x, open_first_y);
			c = $signed(cross_acc);
			if (c == 0) begin
				res.status = STATUS_ZERO;
			end else begin
				sat = 1'b0;
				sx = $signed(moment_x_acc);
				sy = $signed(moment_y_acc);
				res.centroid_x = clamp_coord(sx / (3 * c), sat);
				res.centroid_y = clamp_coord(sy / (3 * c), sat);
				mag = (c < 0) ? -c : c;
				res.doubled_area = mag[AREA_BITS-1:0];
				res.status = sat ? STATUS_SAT : STATUS_OK;
			end
		end

		// Start afresh for the next polygon
		open_first_x = 0;
		open_first_y = 0;
		open_prev_x  = 0;
		open_prev_y  = 0;
		open_count   = 0;
		cross_acc    = '0;
		moment_x_acc = '0;
		moment_y_acc = '0;
		return 1'b1;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] pick_coord(input int span);
		if (span >= 32768)
			return COORD_BITS'($urandom());
		return COORD_BITS'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic vertex_t make_vertex(input logic signed [COORD_BITS-1:0] x,
			input logic signed [COORD_BITS-1:0] y);
		vertex_t v;
		v.vertex_x    = x;
		v.vertex_y    = y;
		v.last_vertex = 1'b0;
		return v;
	endfunction

	// Offer one vertex request in bursts with random gaps, then predict on acceptance
	task automatic send_vertex(input vertex_t v, input bit typed, input result_t typed_res);
		int      gap;
		result_t res;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				vertex_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		vertex_valid <= 1'b1;
		vertex <= v;
		do @(posedge clk); while (vertex_stall);
		vertices_sent++;
		if (shoelace_step(v, res))
			results_due.push_back(typed ? typed_res : res);
	endtask

	// Hold the sender until every predicted result has come back
	task automatic pause_until_drained();
		vertex_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
	endtask

	// Build one random polygon: mostly proper shapes, some degenerate ones
	task automatic send_random_polygon();
		vertex_t ring [$];
		int      shape;
		int      n;
		int      span;
		int      lx;
		int      hy;
		int      p;
		int      t;
		logic signed [COORD_BITS-1:0] bx, by, dx, dy, x0, y0, x1, y1;
		shape = $urandom_range(0, 99);
		span = ($urandom_range(0, 2) == 0) ? 32768 : $urandom_range(1, 2000);
		if (shape < 30) begin
			n = $urandom_range(3, 8);
			repeat (n) ring.push_back(make_vertex(pick_coord(span), pick_coord(span)));
		end else if (shape < 45) begin
			x0 = pick_coord(span);
			y0 = pick_coord(span);
			x1 = pick_coord(span);
			y1 = pick_coord(span);
			ring.push_back(make_vertex(x0, y0));
			ring.push_back(make_vertex(x1, y0));
			ring.push_back(make_vertex(x1, y1));
			ring.push_back(make_vertex(x0, y1));
		end else if (shape < 55) begin
			n = $urandom_range(9, 40);
			repeat (n) ring.push_back(make_vertex(pick_coord(span), pick_coord(span)));
		end else if (shape < 63) begin
			n = $urandom_range(1, 2);
			repeat (n) ring.push_back(make_vertex(pick_coord(32768), pick_coord(32768)));
		end else if (shape < 73) begin
			// points on one line through a base point
			bx = pick_coord(1000);
			by = pick_coord(1000);
			dx = pick_coord(20);
			dy = pick_coord(20);
			n = $urandom_range(3, 6);
			repeat (n) begin
				t = int'($urandom_range(0, 100)) - 50;
				ring.push_back(make_vertex(COORD_BITS'(bx + t * dx),
					COORD_BITS'(by + t * dy)));
			end
		end else if (shape < 83) begin
			// self-crossing bowtie with a small net area
			lx = $urandom_range(10000, 32767);
			if ($urandom_range(0, 1) == 1)
				lx = -lx;
			hy = $urandom_range(500, 32767);
			p = $urandom_range(1, 4);
			ring.push_back(make_vertex(COORD_BITS'(-lx), COORD_BITS'(-hy)));
			ring.push_back(make_vertex(COORD_BITS'(lx), COORD_BITS'(hy)));
			ring.push_back(make_vertex(COORD_BITS'(lx), COORD_BITS'(-hy + p)));
			ring.push_back(make_vertex(COORD_BITS'(-lx), COORD_BITS'(hy)));
		end else begin
			repeat (3) ring.push_back(make_vertex(pick_coord(32768), pick_coord(32768)));
		end
		foreach (ring[i]) begin
			ring[i].last_vertex = (i == ring.size() - 1);
			send_vertex(ring[i], 1'b0, '0);
		end
	endtask

	// Stall the result channel in segments of differing density, after a long hold when one is due
	initial begin : result_stall_pattern
		int mode;
		int seg_len;
		forever begin
			if (hold_off_due) begin
				result_stall <= 1'b1;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_off_due = 1'b0;
			end
			mode = $urandom_range(0, 3);
			seg_len = $urandom_range(8, 120);
			repeat (seg_len) begin
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 1) == 1);
					2: result_stall <= ($urandom_range(0, 7) != 0);
					default: result_stall <= ($urandom_range(0, 7) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// Match each accepted result against the oldest prediction
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (results_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none actual %0d %0d %0d %0d",
					$time, result.centroid_x, result.centroid_y,
					result.doubled_area, result.status);
			end else begin
				want = results_due.pop_front();
				compare_field("centroid_x", want.centroid_x, result.centroid_x);
				compare_field("centroid_y", want.centroid_y, result.centroid_y);
				compare_field("doubled_area", want.doubled_area, result.doubled_area);
				compare_field("status", want.status, result.status);
			end
		end
	end

	initial begin : stimulus
		vertex_t v;
		int      n;
		int      random_start;
		bit      paused_mid;
		open_first_x = 0;
		open_first_y = 0;
		open_prev_x  = 0;
		open_prev_y  = 0;
		open_count   = 0;
		cross_acc    = '0;
		moment_x_acc = '0;
		moment_y_acc = '0;
		paused_mid   = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the corner-case table
		foreach (directed_rows[i])
			send_vertex(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
		pause_until_drained();

		// Polygons right at the vertex limit and just past it
		for (int k = 0; k < 2; k++) begin
			n = (k == 0) ? MAX_VERTICES_DEF : MAX_VERTICES_DEF + 3;
			for (int i = 0; i < n; i++) begin
				v = make_vertex(pick_coord(32768), pick_coord(32768));
				v.last_vertex = (i == n - 1);
				send_vertex(v, n > MAX_VERTICES_DEF, MANY_RESULT);
			end
		end
		pause_until_drained();

		// Random polygons; the receiver holds off early on so the core backs up
		hold_off_due = 1'b1;
		random_start = vertices_sent;
		while (vertices_sent - random_start < RANDOM_VERTICES) begin
			send_random_polygon();
			if (!paused_mid && vertices_sent - random_start >= RANDOM_VERTICES / 2) begin
				pause_until_drained();
				paused_mid = 1'b1;
			end
		end
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Give up if the run hangs
	initial begin : watchdog
		#4_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, results_due.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

### polygon_area_centroid_core.f
+incdir+rtl
rtl/pac_pkg.sv
rtl/polygon_area_centroid_core.sv
test/tb_polygon_area_centroid_core.sv
